// File: hdl/assert_macros.svh
// Assertion macros used by the checker file tpc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled during reset.
`define TPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A signal keeps its value in the cycle after a condition.
`define TPC_ASSERT_HOLD(lbl, clk, rst, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// File: hdl/tpc_pkg.sv
// Types and constants of the passive-open TCP connection state machine.
package tpc_pkg;

  localparam int CFG_IDX_W = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_PORT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADV_WINDOW  = 4'd1;

  localparam logic [15:0] LISTEN_PORT_RESET = 16'd0;
  localparam logic [15:0] ADV_WINDOW_RESET  = 16'd2;

  // Connection states
  localparam logic [1:0] ST_LISTEN      = 2'd0;
  localparam logic [1:0] ST_SYN_RCVD    = 2'd1;
  localparam logic [1:0] ST_ESTABLISHED = 2'd2;
  localparam logic [1:0] ST_LAST_ACK    = 2'd3;

  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] peer_seq;
    logic [31:0] peer_ack;
    logic        in_ack;
    logic        in_rst;
    logic        in_syn;
    logic        in_fin;
    logic [15:0] payload_len;
    logic [31:0] initial_seq;
  } seg_t;

  typedef struct packed {
    logic        send;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [31:0] out_seq;
    logic [31:0] out_ack_num;
    logic        out_ack;
    logic        out_rst;
    logic        out_syn;
    logic        out_fin;
    logic [15:0] out_window;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  conn_state;
    logic [15:0] peer_port;
    logic [31:0] our_seq;
    logic [31:0] expected_seq;
  } state_t;

endpackage

// File: hdl/tpc_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
interface tpc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/tpc_cfg_regs.sv
// Configuration registers: listening port and advertised window.
module tpc_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  tpc_stream_if.sink  cfg,
  output logic [15:0] listen_port,
  output logic [15:0] adv_window
);
  import tpc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port <= LISTEN_PORT_RESET;
      adv_window  <= ADV_WINDOW_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        REG_LISTEN_PORT: listen_port <= cfg.payload.data;
        REG_ADV_WINDOW:  adv_window  <= cfg.payload.data;
        default: ;
      endcase
    end
  end
endmodule

// File: hdl/tpc_decide.sv
// Next-state and response logic for one incoming segment.
module tpc_decide (
  input  tpc_pkg::seg_t    seg,
  input  tpc_pkg::state_t  state,
  input  logic [15:0]      listen_port,
  input  logic [15:0]      adv_window,
  output tpc_pkg::state_t  state_next,
  output tpc_pkg::result_t result
);
  import tpc_pkg::*;

  logic        do_send;
  logic        do_reset;
  logic [31:0] seq_v;
  logic [31:0] ack_v;
  logic        f_ack;
  logic        f_syn;
  logic        f_fin;
  logic [31:0] data_end;
  logic        bad_ack;

  // peer_seq + payload_len, plus one when FIN consumes a sequence number
  assign data_end = seg.peer_seq + {16'd0, seg.payload_len} + {31'd0, seg.in_fin};
  assign bad_ack  = !seg.in_ack || seg.in_syn || seg.in_fin ||
                    (state.expected_seq != seg.peer_seq);

  always_comb begin
    state_next = state;
    do_send    = 1'b0;
    do_reset   = 1'b0;
    seq_v      = state.our_seq;
    ack_v      = state.expected_seq;
    f_ack      = 1'b0;
    f_syn      = 1'b0;
    f_fin      = 1'b0;

    if (seg.dst_port != listen_port) begin
      // not for us
    end else if (state.conn_state != ST_LISTEN && state.peer_port != seg.src_port) begin
      do_reset = 1'b1;
    end else if (seg.in_rst) begin
      state_next.conn_state = ST_LISTEN;
    end else begin
      unique case (state.conn_state)
        ST_LISTEN: begin
          if (seg.in_ack || !seg.in_syn || seg.in_fin) begin
            do_reset = 1'b1;
          end else begin
            state_next.peer_port    = seg.src_port;
            state_next.expected_seq = seg.peer_seq + 32'd1;
            state_next.our_seq      = seg.initial_seq + 32'd1;
            state_next.conn_state   = ST_SYN_RCVD;
            do_send = 1'b1;
            seq_v   = seg.initial_seq;
            ack_v   = seg.peer_seq + 32'd1;
            f_ack   = 1'b1;
            f_syn   = 1'b1;
          end
        end
        ST_SYN_RCVD: begin
          if (bad_ack) begin
            do_reset = 1'b1;
          end else begin
            state_next.conn_state = ST_ESTABLISHED;
          end
        end
        ST_ESTABLISHED: begin
          if (seg.in_syn) begin
            do_reset = 1'b1;
          end else if (seg.in_fin || seg.payload_len != 16'd0) begin
            state_next.expected_seq = data_end;
            do_send = 1'b1;
            ack_v   = data_end;
            f_ack   = 1'b1;
            f_fin   = seg.in_fin;
            if (seg.in_fin) begin
              state_next.conn_state = ST_LAST_ACK;
            end
          end
        end
        ST_LAST_ACK: begin
          if (bad_ack) begin
            do_reset = 1'b1;
          end else begin
            state_next.conn_state = ST_LISTEN;
          end
        end
        default: ;
      endcase
    end

    if (do_reset) begin
      state_next.conn_state = ST_LISTEN;
    end

    result = '0;
    if (do_send || do_reset) begin
      result.send         = 1'b1;
      result.out_src_port = listen_port;
      result.out_dst_port = state_next.peer_port;
      result.out_seq      = seq_v;
      result.out_ack_num  = ack_v;
      result.out_ack      = f_ack;
      result.out_rst      = do_reset;
      result.out_syn      = f_syn;
      result.out_fin      = f_fin;
      result.out_window   = adv_window;
    end
  end
endmodule

// File: hdl/tcp_passive_connection_fsm.sv
// Top level of the passive-open TCP connection state machine.
// A segment is registered at the input; its result is registered at the output when the output is free.
// Throughput: one segment per cycle while the output is taken; the next state is registered with the result.
// One more input is taken while a result waits; then input ready follows output ready.
// Reset (rst, synchronous): state LISTEN, peer port and sequence numbers zero,
// listening port 0, window 2; no clearing pass, usable in the next cycle.
module tcp_passive_connection_fsm (
  input  logic         clk,
  input  logic         rst,
  tpc_stream_if.sink   cfg,
  tpc_stream_if.sink   seg_in,
  tpc_stream_if.source seg_out
);
  import tpc_pkg::*;

  logic [15:0] listen_port;
  logic [15:0] adv_window;

  logic    in_valid;
  seg_t    in_data;
  logic    out_valid;
  result_t out_data;
  state_t  state;
  state_t  state_next;
  result_t result;
  logic    advance;

  tpc_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .listen_port (listen_port),
    .adv_window  (adv_window)
  );

  tpc_decide u_decide (
    .seg         (in_data),
    .state       (state),
    .listen_port (listen_port),
    .adv_window  (adv_window),
    .state_next  (state_next),
    .result      (result)
  );

  assign advance      = in_valid && (!out_valid || seg_out.ready);
  assign seg_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (seg_in.valid && seg_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_in.valid && seg_in.ready) begin
      in_data <= seg_in.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.conn_state   <= ST_LISTEN;
      state.peer_port    <= '0;
      state.our_seq      <= '0;
      state.expected_seq <= '0;
      out_valid          <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (seg_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign seg_out.valid   = out_valid;
  assign seg_out.payload = out_data;
endmodule

// File: hdl/tpc_checker.sv
// Port-level checks on the response channel of the connection state machine.
`include "assert_macros.svh"

module tpc_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input tpc_pkg::result_t out_payload
);
  import tpc_pkg::*;

  `TPC_ASSERT_HOLD(a_out_hold, clk, rst, out_valid && !out_ready, out_payload, "stalled result changed")

  `TPC_ASSERT(a_idle_zero, clk, rst, out_valid && !out_payload.send |-> out_payload == '0, "non-send result carries data")

  `TPC_ASSERT(a_rst_alone, clk, rst, out_valid && out_payload.send && out_payload.out_rst |-> !out_payload.out_ack && !out_payload.out_syn && !out_payload.out_fin, "RST segment with extra flags")

  `TPC_ASSERT(a_fin_ack, clk, rst, out_valid && out_payload.send && (out_payload.out_fin || out_payload.out_syn) |-> out_payload.out_ack && !out_payload.out_rst, "SYN or FIN response without ACK")

endmodule

bind tcp_passive_connection_fsm tpc_checker u_tpc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (seg_out.valid),
  .out_ready   (seg_out.ready),
  .out_payload (seg_out.payload)
);

// File: tb/tcp_passive_connection_fsm_tb.sv
// Self-checking testbench: drives parsed TCP headers into the passive-open FSM and checks replies.
module tcp_passive_connection_fsm_tb;
  import tpc_pkg::*;

  // Flag nibble order: {ACK, RST, SYN, FIN}
  localparam logic [3:0] FLAG_ACK = 4'b1000;
  localparam logic [3:0] FLAG_RST = 4'b0100;
  localparam logic [3:0] FLAG_SYN = 4'b0010;
  localparam logic [3:0] FLAG_FIN = 4'b0001;
  localparam logic [3:0] FLAG_NONE = 4'b0000;

  localparam int unsigned PHASES = 5;
  localparam int unsigned ITEMS_PER_PHASE = 265;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam result_t NO_REPLY = '0;
  localparam result_t RST_AT_RESET = '{send: 1'b1, out_src_port: 16'h0000,
      out_dst_port: 16'h0000, out_seq: 32'h0, out_ack_num: 32'h0, out_ack: 1'b0,
      out_rst: 1'b1, out_syn: 1'b0, out_fin: 1'b0, out_window: 16'd2};
  localparam result_t SYNACK_WRAP = '{send: 1'b1, out_src_port: 16'h0000,
      out_dst_port: 16'hFFFF, out_seq: 32'hFFFF_FFFF, out_ack_num: 32'h0, out_ack: 1'b1,
      out_rst: 1'b0, out_syn: 1'b1, out_fin: 1'b0, out_window: 16'd2};

  typedef struct {
    seg_t    seg;
    bit      typed;
    result_t reply;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpc_stream_if #(.payload_t(cfg_t))    cfg_if ();
  tpc_stream_if #(.payload_t(seg_t))    seg_in_if ();
  tpc_stream_if #(.payload_t(result_t)) seg_out_if ();

  tcp_passive_connection_fsm dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .seg_in  (seg_in_if),
    .seg_out (seg_out_if)
  );

  always #4 clk = ~clk;

  // Connection model state and register copies
  logic [15:0] listen_port_r  = LISTEN_PORT_RESET;
  logic [15:0] window_r       = ADV_WINDOW_RESET;
  logic [1:0]  conn_state_r   = ST_LISTEN;
  logic [15:0] peer_port_r    = '0;
  logic [31:0] our_seq_r      = '0;
  logic [31:0] expected_seq_r = '0;

  result_t     expected_replies[$];
  int unsigned mismatches = 0;
  int unsigned segments_sent = 0;
  int unsigned replies_seen = 0;
  int unsigned idle_cycles = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;

  function automatic int unsigned pick_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic seg_t mk_seg(logic [15:0] src, logic [15:0] dst, logic [31:0] seq,
                                  logic [3:0] flags, logic [15:0] plen, logic [31:0] iseq);
    seg_t s;
    s.src_port = src;
    s.dst_port = dst;
    s.peer_seq = seq;
    s.peer_ack = $urandom();
    {s.in_ack, s.in_rst, s.in_syn, s.in_fin} = flags;
    s.payload_len = plen;
    s.initial_seq = iseq;
    return s;
  endfunction

  function automatic result_t make_reply(logic [31:0] seq, logic [31:0] ackn,
                                         logic [3:0] flags);
    result_t r;
    r.send = 1'b1;
    r.out_src_port = listen_port_r;
    r.out_dst_port = peer_port_r;
    r.out_seq = seq;
    r.out_ack_num = ackn;
    {r.out_ack, r.out_rst, r.out_syn, r.out_fin} = flags;
    r.out_window = window_r;
    return r;
  endfunction

  // Advances the connection model by one segment and returns the reply it causes.
  function automatic result_t predict_reply(seg_t s);
    result_t r;
    bit      bad;
    r = NO_REPLY;
    if (s.dst_port != listen_port_r) return r;
    // foreign peer wins over the incoming RST flag
    bad = (conn_state_r != ST_LISTEN) && (s.src_port != peer_port_r);
    if (!bad && s.in_rst) begin
      conn_state_r = ST_LISTEN;
      return r;
    end
    if (!bad) begin
      case (conn_state_r)
        ST_LISTEN: begin
          if (s.in_ack || !s.in_syn || s.in_fin) begin
            bad = 1'b1;
          end else begin
            peer_port_r = s.src_port;
            expected_seq_r = s.peer_seq + 32'd1;
            r = make_reply(s.initial_seq, expected_seq_r, FLAG_ACK | FLAG_SYN);
            our_seq_r = s.initial_seq + 32'd1;
            conn_state_r = ST_SYN_RCVD;
          end
        end
        ST_ESTABLISHED: begin
          if (s.in_syn) begin
            bad = 1'b1;
          end else if (s.in_fin) begin
            // FIN takes one sequence number
            expected_seq_r = s.peer_seq + 32'(s.payload_len) + 32'd1;
            r = make_reply(our_seq_r, expected_seq_r, FLAG_ACK | FLAG_FIN);
            conn_state_r = ST_LAST_ACK;
          end else if (s.payload_len != 16'd0) begin
            expected_seq_r = s.peer_seq + 32'(s.payload_len);
            r = make_reply(our_seq_r, expected_seq_r, FLAG_ACK);
          end
        end
        default: begin
          if (!s.in_ack || s.in_syn || s.in_fin || expected_seq_r != s.peer_seq)
            bad = 1'b1;
          else
            conn_state_r = (conn_state_r == ST_SYN_RCVD) ? ST_ESTABLISHED : ST_LISTEN;
        end
      endcase
    end
    if (bad) begin
      r = make_reply(our_seq_r, expected_seq_r, FLAG_RST);
      conn_state_r = ST_LISTEN;
    end
    return r;
  endfunction

  // Mostly legal traffic that follows the connection; the rest is noise.
  function automatic seg_t next_segment();
    seg_t       s;
    logic [3:0] flags;
    s = mk_seg(16'($urandom()), listen_port_r, expected_seq_r, FLAG_NONE,
               16'($urandom_range(0, 64)), $urandom());
    if (conn_state_r != ST_LISTEN && $urandom_range(0, 31) != 0) s.src_port = peer_port_r;
    if ($urandom_range(0, 15) == 0) s.payload_len = 16'hFFFF;
    if ($urandom_range(0, 9) < 8) begin
      case (conn_state_r)
        ST_LISTEN: begin
          flags = FLAG_SYN;
          s.peer_seq = $urandom();
        end
        ST_ESTABLISHED: flags = ($urandom_range(0, 4) == 0) ? (FLAG_ACK | FLAG_FIN) : FLAG_ACK;
        default: flags = FLAG_ACK;
      endcase
    end else begin
      flags = 4'($urandom());
      if ($urandom_range(0, 1) == 0) s.peer_seq = $urandom();
      if ($urandom_range(0, 3) == 0) s.dst_port = 16'($urandom());
      s.payload_len = 16'($urandom());
    end
    {s.in_ack, s.in_rst, s.in_syn, s.in_fin} = flags;
    return s;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    mismatches++;
  endtask

  task automatic check_reply(result_t got);
    result_t want;
    if (expected_replies.size() == 0) begin
      $error("reply segment with no transaction pending");
      mismatches++;
      return;
    end
    want = expected_replies.pop_front();
    if (got.send !== want.send) report_field("send", want.send, got.send);
    if (got.out_src_port !== want.out_src_port)
      report_field("out_src_port", want.out_src_port, got.out_src_port);
    if (got.out_dst_port !== want.out_dst_port)
      report_field("out_dst_port", want.out_dst_port, got.out_dst_port);
    if (got.out_seq !== want.out_seq) report_field("out_seq", want.out_seq, got.out_seq);
    if (got.out_ack_num !== want.out_ack_num)
      report_field("out_ack_num", want.out_ack_num, got.out_ack_num);
    if (got.out_ack !== want.out_ack) report_field("out_ack", want.out_ack, got.out_ack);
    if (got.out_rst !== want.out_rst) report_field("out_rst", want.out_rst, got.out_rst);
    if (got.out_syn !== want.out_syn) report_field("out_syn", want.out_syn, got.out_syn);
    if (got.out_fin !== want.out_fin) report_field("out_fin", want.out_fin, got.out_fin);
    if (got.out_window !== want.out_window)
      report_field("out_window", want.out_window, got.out_window);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_if.payload <= '{index: idx, data: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_LISTEN_PORT) listen_port_r = val;
    else if (idx == REG_ADV_WINDOW) window_r = val;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_segment(seg_t s, bit typed, result_t typed_reply);
    int unsigned gap;
    result_t     predicted;
    if (segments_sent % 50 == 0) src_burst = ($urandom_range(0, 3) == 0);
    gap = pick_wait(src_burst);
    if (gap != 0) begin
      seg_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_in_if.payload <= s;
    seg_in_if.valid <= 1'b1;
    do @(posedge clk); while (!seg_in_if.ready);
    predicted = predict_reply(s);
    expected_replies.push_back(typed ? typed_reply : predicted);
    segments_sent++;
  endtask

  // Hold the sender until every reply is back and the pipe is empty.
  task automatic drain();
    seg_in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t    dir_rows[$];
    logic [15:0] port;
    logic [15:0] win;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    seg_in_if.valid = 1'b0;
    seg_in_if.payload = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Runs at reset settings: local port 0, window 2
    dir_rows = '{
      '{mk_seg(16'h0001, 16'h0001, 32'h0, FLAG_SYN, 16'h0, 32'h0), 1'b1, NO_REPLY},
      '{mk_seg(16'hFFFF, 16'h0000, 32'h0, FLAG_ACK | FLAG_SYN, 16'h0, 32'h0), 1'b1,
        RST_AT_RESET},
      '{mk_seg(16'hFFFF, 16'h0000, 32'h0, FLAG_RST | FLAG_SYN, 16'h0, 32'h0), 1'b1, NO_REPLY},
      '{mk_seg(16'hFFFF, 16'h0000, 32'h0, FLAG_SYN | FLAG_FIN, 16'h0, 32'h0), 1'b1,
        RST_AT_RESET},
      '{mk_seg(16'hFFFF, 16'h0000, 32'h0, FLAG_NONE, 16'hFFFF, 32'h0), 1'b1, RST_AT_RESET},
      '{mk_seg(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, FLAG_SYN, 16'h0, 32'hFFFF_FFFF), 1'b1,
        SYNACK_WRAP},
      '{mk_seg(16'hFFFF, 16'h0000, 32'd5, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd100, FLAG_SYN, 16'h0, 32'd1000), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd101, FLAG_ACK | FLAG_SYN, 16'h0, 32'h0), 1'b0,
        NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'hFFFF_FFF0, FLAG_SYN, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'hFFFF_FFF1, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'hFFFF_FFF1, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'hFFFF_FFF1, FLAG_ACK, 16'h20, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h4321, 16'h0000, 32'h11, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd7, FLAG_SYN, 16'h0, 32'd50), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd8, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd8, FLAG_ACK | FLAG_FIN, 16'd3, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd12, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd7, FLAG_SYN, 16'h0, 32'd50), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd8, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd8, FLAG_ACK | FLAG_SYN, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd0, FLAG_SYN, 16'h0, 32'd50), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd1, FLAG_ACK, 16'h0, 32'h0), 1'b0, NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'd1, FLAG_ACK | FLAG_FIN, 16'hFFFF, 32'h0), 1'b0,
        NO_REPLY},
      '{mk_seg(16'h1234, 16'h0000, 32'h0, FLAG_ACK | FLAG_RST, 16'h0, 32'h0), 1'b0, NO_REPLY}
    };
    foreach (dir_rows[i]) send_segment(dir_rows[i].seg, dir_rows[i].typed, dir_rows[i].reply);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin port = 16'hFFFF; win = 16'h0000; end
        1: begin port = 16'h0000; win = 16'hFFFF; end
        3: begin port = 16'h1F90; win = 16'h0400; end
        default: begin port = 16'($urandom()); win = 16'($urandom()); end
      endcase
      write_reg(REG_LISTEN_PORT, port);
      write_reg(REG_ADV_WINDOW, win);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain();
        send_segment(next_segment(), 1'b0, NO_REPLY);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : reply_sink
    int unsigned stall;
    seg_out_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (replies_seen % 40 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      stall = pick_wait(sink_burst);
      if (stall != 0) begin
        seg_out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      seg_out_if.ready <= 1'b1;
      do @(posedge clk); while (!seg_out_if.valid);
      check_reply(seg_out_if.payload);
      replies_seen++;
    end
  end

  // Ends a hung run: counts cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (cfg_if.valid && cfg_if.ready) || (seg_in_if.valid && seg_in_if.ready) ||
        (seg_out_if.valid && seg_out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
